FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the stick channel shaper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define STCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define STCS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/stcs_pkg.sv
// ----------------------------------------------------------------------------
// stcs_pkg
// Shared types and constants of the stick channel shaper pipeline.
// ----------------------------------------------------------------------------
package stcs_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 8;

    // divider geometry: 16-bit dividend, 8-bit divisor, 8-bit quotient
    localparam int DVS_W     = 8;
    localparam int PROD_W    = 2 * DVS_W;
    localparam int DIV_STEPS = DVS_W;

    // expo curve widths
    localparam int CUBE_W      = 22;
    localparam int WCUBE_W     = 29;
    localparam int RECIP_W     = 30;
    localparam int Q1_W        = 16;
    localparam int EXPO_SHIFT  = 43;
    localparam int PCT_SHIFT   = 19;
    localparam int PCT_PROD_W  = 29;
    localparam int Q2_W        = 10;
    localparam int FULL_SHIFT  = 23;

    // rounded-up reciprocals for the constant divisors 127*127, 100 and 255
    localparam logic [RECIP_W-1:0] EXPO_RECIP =
        RECIP_W'((64'd1 << EXPO_SHIFT) / 64'd16129 + 64'd1);
    localparam logic [12:0] PCT_RECIP =
        13'((32'd1 << PCT_SHIFT) / 32'd100 + 32'd1);
    localparam logic [15:0] FULL_RECIP =
        16'((32'd1 << FULL_SHIFT) / 32'd255 + 32'd1);

    localparam logic [7:0]         FULL_SCALE = 8'd255;
    localparam logic signed [8:0]  CURVE_MID  = 9'sd127;
    localparam logic signed [7:0]  PCT_FULL   = 8'sd100;
    localparam logic signed [10:0] CENTER     = 11'sd90;
    localparam logic [7:0]         POS_MAX    = 8'd180;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_END       = 3'd0,
        CFG_HIGH_END      = 3'd1,
        CFG_TRAVEL_RANGE  = 3'd2,
        CFG_TRIM_OFFSET   = 3'd3,
        CFG_EXPO_PERCENT  = 3'd4,
        CFG_INVERT_OUTPUT = 3'd5,
        CFG_THROTTLE_MODE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]        low_end;
        logic [7:0]        high_end;
        logic [6:0]        travel_range;
        logic signed [7:0] trim_offset;
        logic [6:0]        expo_percent;
        logic              invert_output;
        logic              throttle_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        low_end:       8'd0,
        high_end:      8'd255,
        travel_range:  7'd90,
        trim_offset:   8'sd0,
        expo_percent:  7'd0,
        invert_output: 1'b0,
        throttle_mode: 1'b0
    };

endpackage

FILE: hdl/stcs_front.sv
// ----------------------------------------------------------------------------
// stcs_front
// Clamp the reading to the calibrated ends and form the map dividend.
// ----------------------------------------------------------------------------
module stcs_front #(
    parameter int SAMPLE_BITS = stcs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stcs_pkg::t_cfg              i_cfg,
    input  logic                        i_vld,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    output logic                        o_rdy,
    input  logic                        i_nxt_rdy,
    output logic                        o_vld,
    output logic [stcs_pkg::PROD_W-1:0] o_dvd,
    output logic [stcs_pkg::DVS_W-1:0]  o_dvs,
    output logic                        o_zero
);

    logic [1:0] r_vld;
    logic [1:0] rdy;

    logic [SAMPLE_BITS-1:0] v;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] vc;
    logic [7:0]             vc8;

    logic [7:0] n_a_dmag, r_a_dmag;
    logic [7:0] n_a_smag, r_a_smag;
    logic [7:0] n_a_scale, r_a_scale;
    logic       n_a_zero, r_a_zero;

    logic [stcs_pkg::PROD_W-1:0] n_b_dvd, r_b_dvd;
    logic [stcs_pkg::DVS_W-1:0]  r_b_dvs;
    logic                        r_b_zero;

    always_comb begin
        rdy[1] = !r_vld[1] || i_nxt_rdy;
        rdy[0] = !r_vld[0] || rdy[1];
    end
    assign o_rdy = rdy[0];

    always_comb begin
        v  = {2'b00, i_sample[SAMPLE_BITS-1:2]};
        lo = SAMPLE_BITS'(i_cfg.low_end);
        hi = SAMPLE_BITS'(i_cfg.high_end);
        priority if (v < lo) begin
            vc = lo;
        end else if (v > hi) begin
            vc = hi;
        end else begin
            vc = v;
        end
        // clamped value never exceeds the larger end, so it fits a byte
        vc8 = vc[7:0];
        n_a_dmag  = (vc8 >= i_cfg.low_end) ? vc8 - i_cfg.low_end : i_cfg.low_end - vc8;
        n_a_smag  = (i_cfg.high_end >= i_cfg.low_end) ? i_cfg.high_end - i_cfg.low_end
                                                      : i_cfg.low_end - i_cfg.high_end;
        n_a_zero  = (i_cfg.high_end == i_cfg.low_end);
        n_a_scale = i_cfg.throttle_mode ? {i_cfg.travel_range, 1'b0}
                                        : stcs_pkg::FULL_SCALE;
    end

    // both distances carry the same sign, so magnitudes keep the quotient
    assign n_b_dvd = stcs_pkg::PROD_W'(r_a_dmag) * stcs_pkg::PROD_W'(r_a_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            if (rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_a_dmag  <= n_a_dmag;
            r_a_smag  <= n_a_smag;
            r_a_scale <= n_a_scale;
            r_a_zero  <= n_a_zero;
        end
        if (rdy[1]) begin
            r_b_dvd  <= n_b_dvd;
            r_b_dvs  <= r_a_smag;
            r_b_zero <= r_a_zero;
        end
    end

    assign o_vld  = r_vld[1];
    assign o_dvd  = r_b_dvd;
    assign o_dvs  = r_b_dvs;
    assign o_zero = r_b_zero;

endmodule

FILE: hdl/stcs_div.sv
// ----------------------------------------------------------------------------
// stcs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stcs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [stcs_pkg::PROD_W-1:0] i_dvd,
    input  logic [stcs_pkg::DVS_W-1:0]  i_dvs,
    input  logic                        i_zero,
    output logic                        o_rdy,
    input  logic                        i_nxt_rdy,
    output logic                        o_vld,
    output logic [stcs_pkg::DVS_W-1:0]  o_quot
);

    localparam int NS   = stcs_pkg::DIV_STEPS;
    localparam int LAST = NS - 1;
    localparam int W    = stcs_pkg::DVS_W;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] r_zero;
    logic [NS-1:0] rdy;
    logic [NS-1:0] p_vld;
    logic [NS-1:0] p_zero;

    logic [W-1:0] r_rem [NS];
    logic [W-1:0] r_low [NS];
    logic [W-1:0] r_q   [NS];
    logic [W-1:0] r_dvs [NS];
    logic [W-1:0] p_rem [NS];
    logic [W-1:0] p_low [NS];
    logic [W-1:0] p_q   [NS];
    logic [W-1:0] p_dvs [NS];
    logic [W-1:0] n_rem [NS];
    logic [W-1:0] n_low [NS];
    logic [W-1:0] n_q   [NS];

    always_comb begin
        rdy[LAST] = !r_vld[LAST] || i_nxt_rdy;
        for (int i = LAST - 1; i >= 0; i--) begin
            rdy[i] = !r_vld[i] || rdy[i+1];
        end
    end
    assign o_rdy = rdy[0];

    assign p_vld  = {r_vld[NS-2:0], i_vld};
    assign p_zero = {r_zero[NS-2:0], i_zero};

    // the upper dividend byte is below the divisor, so it seeds the remainder
    always_comb begin
        p_rem[0] = i_dvd[stcs_pkg::PROD_W-1:W];
        p_low[0] = i_dvd[W-1:0];
        p_q[0]   = '0;
        p_dvs[0] = i_dvs;
        for (int i = 1; i < NS; i++) begin
            p_rem[i] = r_rem[i-1];
            p_low[i] = r_low[i-1];
            p_q[i]   = r_q[i-1];
            p_dvs[i] = r_dvs[i-1];
        end
    end

    always_comb begin
        logic [W:0] trial;
        logic [W:0] diff;
        logic       ge;
        for (int i = 0; i < NS; i++) begin
            trial    = {p_rem[i], p_low[i][W-1]};
            diff     = trial - {1'b0, p_dvs[i]};
            ge       = (trial >= {1'b0, p_dvs[i]});
            n_rem[i] = ge ? diff[W-1:0] : trial[W-1:0];
            n_low[i] = {p_low[i][W-2:0], 1'b0};
            n_q[i]   = {p_q[i][W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (rdy[i]) begin
                    r_vld[i] <= p_vld[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
                r_rem[i]  <= n_rem[i];
                r_low[i]  <= n_low[i];
                r_q[i]    <= n_q[i];
                r_dvs[i]  <= p_dvs[i];
                r_zero[i] <= p_zero[i];
            end
        end
    end

    assign o_vld = r_vld[LAST];
    // a zero span maps to the bottom of the output range
    assign o_quot = r_zero[LAST] ? '0 : r_q[LAST];

    `STCS_ASSERT(a_rem_below_dvs, r_vld[LAST] && !r_zero[LAST] |-> r_rem[LAST] < r_dvs[LAST], "divider remainder not below divisor")

endmodule

FILE: hdl/stcs_expo.sv
// ----------------------------------------------------------------------------
// stcs_expo
// Cubic expo curve on the 0 to 255 stick value, six register stages.
// ----------------------------------------------------------------------------
module stcs_expo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stcs_pkg::t_cfg i_cfg,
    input  logic           i_vld,
    input  logic [7:0]     i_quot,
    output logic           o_rdy,
    input  logic           i_nxt_rdy,
    output logic           o_vld,
    output logic [7:0]     o_curve,
    output logic [7:0]     o_quot
);

    localparam int NS = 6;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] rdy;

    // stage 1: offset from mid and square of its magnitude
    logic signed [8:0] n1_x, r1_x;
    logic [7:0]        n1_m, r1_m;
    logic [15:0]       n1_m2, r1_m2;
    logic [7:0]        r1_q;
    // stage 2: cube and linear term
    logic [stcs_pkg::CUBE_W-1:0] n2_m3, r2_m3;
    logic signed [7:0]           n2_kw;
    logic signed [16:0]          n2_t2, r2_t2;
    logic                        r2_neg;
    logic [7:0]                  r2_q;
    // stage 3: weighted cube
    logic [stcs_pkg::WCUBE_W-1:0] n3_p, r3_p;
    logic signed [16:0]           r3_t2;
    logic                         r3_neg;
    logic [7:0]                   r3_q;
    // stage 4: divide by 127 squared
    logic [stcs_pkg::WCUBE_W+stcs_pkg::RECIP_W-1:0] n4_prod;
    logic [stcs_pkg::Q1_W-1:0]                      r4_q1;
    logic signed [16:0]                             r4_t2;
    logic                                           r4_neg;
    logic [7:0]                                     r4_q;
    // stage 5: signed sum split into sign and magnitude
    logic signed [17:0]        n5_q1s;
    logic signed [17:0]        n5_s;
    logic                      n5_neg, r5_neg;
    logic [15:0]               n5_mag, r5_mag;
    logic [7:0]                r5_q;
    // stage 6: divide by 100, recenter and clamp
    logic [stcs_pkg::PCT_PROD_W-1:0] n6_prod;
    logic [stcs_pkg::Q2_W-1:0]       n6_q2;
    logic signed [11:0]              n6_q2s;
    logic signed [11:0]              n6_ys;
    logic [7:0]                      n6_y, r6_y;
    logic [7:0]                      r6_q;

    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || i_nxt_rdy;
        for (int i = NS - 2; i >= 0; i--) begin
            rdy[i] = !r_vld[i] || rdy[i+1];
        end
    end
    assign o_rdy = rdy[0];

    always_comb begin
        n1_x  = $signed({1'b0, i_quot}) - stcs_pkg::CURVE_MID;
        n1_m  = n1_x[8] ? 8'(-n1_x) : n1_x[7:0];
        n1_m2 = 16'(n1_m) * 16'(n1_m);

        n2_m3 = stcs_pkg::CUBE_W'(r1_m2) * stcs_pkg::CUBE_W'(r1_m);
        n2_kw = stcs_pkg::PCT_FULL - $signed({1'b0, i_cfg.expo_percent});
        n2_t2 = 17'(r1_x) * 17'(n2_kw);

        n3_p = stcs_pkg::WCUBE_W'(r2_m3) * stcs_pkg::WCUBE_W'(i_cfg.expo_percent);

        n4_prod = (stcs_pkg::WCUBE_W + stcs_pkg::RECIP_W)'(r3_p)
                * (stcs_pkg::WCUBE_W + stcs_pkg::RECIP_W)'(stcs_pkg::EXPO_RECIP);

        // truncate toward zero: divide the magnitude, then restore the sign
        n5_q1s = $signed({2'b00, r4_q1});
        n5_s   = (r4_neg ? -n5_q1s : n5_q1s) + 18'(r4_t2);
        n5_neg = n5_s[17];
        n5_mag = 16'(n5_neg ? -n5_s : n5_s);

        n6_prod = stcs_pkg::PCT_PROD_W'(r5_mag) * stcs_pkg::PCT_PROD_W'(stcs_pkg::PCT_RECIP);
        n6_q2   = n6_prod[stcs_pkg::PCT_SHIFT +: stcs_pkg::Q2_W];
        n6_q2s  = $signed({2'b00, n6_q2});
        n6_ys   = (r5_neg ? -n6_q2s : n6_q2s) + 12'(stcs_pkg::CURVE_MID);
        priority if (n6_ys < 12'sd0) begin
            n6_y = '0;
        end else if (n6_ys > $signed({4'b0000, stcs_pkg::FULL_SCALE})) begin
            n6_y = stcs_pkg::FULL_SCALE;
        end else begin
            n6_y = n6_ys[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_x  <= n1_x;
            r1_m  <= n1_m;
            r1_m2 <= n1_m2;
            r1_q  <= i_quot;
        end
        if (rdy[1]) begin
            r2_m3  <= n2_m3;
            r2_t2  <= n2_t2;
            r2_neg <= r1_x[8];
            r2_q   <= r1_q;
        end
        if (rdy[2]) begin
            r3_p   <= n3_p;
            r3_t2  <= r2_t2;
            r3_neg <= r2_neg;
            r3_q   <= r2_q;
        end
        if (rdy[3]) begin
            r4_q1  <= n4_prod[stcs_pkg::EXPO_SHIFT +: stcs_pkg::Q1_W];
            r4_t2  <= r3_t2;
            r4_neg <= r3_neg;
            r4_q   <= r3_q;
        end
        if (rdy[4]) begin
            r5_neg <= n5_neg;
            r5_mag <= n5_mag;
            r5_q   <= r4_q;
        end
        if (rdy[5]) begin
            r6_y <= n6_y;
            r6_q <= r5_q;
        end
    end

    assign o_vld   = r_vld[NS-1];
    assign o_curve = r6_y;
    assign o_quot  = r6_q;

endmodule

FILE: hdl/stcs_back.sv
// ----------------------------------------------------------------------------
// stcs_back
// Outside throttle mode map onto travel around center; trim, clamp, mirror.
// ----------------------------------------------------------------------------
module stcs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stcs_pkg::t_cfg i_cfg,
    input  logic           i_vld,
    input  logic [7:0]     i_curve,
    input  logic [7:0]     i_quot,
    output logic           o_rdy,
    input  logic           i_nxt_rdy,
    output logic           o_vld,
    output logic [7:0]     o_pos
);

    localparam int NS = 3;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] rdy;

    logic [15:0]        n1_n, r1_n;
    logic [7:0]         r1_q;
    logic [31:0]        n2_prod;
    logic [7:0]         r2_f;
    logic [7:0]         r2_q;
    logic signed [10:0] n3_base;
    logic signed [10:0] n3_val;
    logic [7:0]         n3_clip;
    logic [7:0]         n3_pos, r3_pos;

    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || i_nxt_rdy;
        for (int i = NS - 2; i >= 0; i--) begin
            rdy[i] = !r_vld[i] || rdy[i+1];
        end
    end
    assign o_rdy = rdy[0];

    always_comb begin
        n1_n    = 16'(i_curve) * 16'({i_cfg.travel_range, 1'b0});
        n2_prod = 32'(r1_n) * 32'(stcs_pkg::FULL_RECIP);

        if (i_cfg.throttle_mode) begin
            n3_base = $signed({3'b000, r2_q});
        end else begin
            n3_base = $signed({3'b000, r2_f}) + stcs_pkg::CENTER
                    - $signed({4'b0000, i_cfg.travel_range});
        end
        n3_val = n3_base + 11'(i_cfg.trim_offset);
        priority if (n3_val < 11'sd0) begin
            n3_clip = '0;
        end else if (n3_val > $signed({3'b000, stcs_pkg::POS_MAX})) begin
            n3_clip = stcs_pkg::POS_MAX;
        end else begin
            n3_clip = n3_val[7:0];
        end
        n3_pos = i_cfg.invert_output ? stcs_pkg::POS_MAX - n3_clip : n3_clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int i = 1; i < NS; i++) begin
                if (rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_n <= n1_n;
            r1_q <= i_quot;
        end
        if (rdy[1]) begin
            r2_f <= n2_prod[stcs_pkg::FULL_SHIFT +: 8];
            r2_q <= r1_q;
        end
        if (rdy[2]) begin
            r3_pos <= n3_pos;
        end
    end

    assign o_vld = r_vld[NS-1];
    assign o_pos = r3_pos;

endmodule

FILE: hdl/stick_channel_shaper_unit.sv
// ----------------------------------------------------------------------------
// stick_channel_shaper_unit
// Shapes a filtered stick reading into a 0 to 180 degree channel position.
// ----------------------------------------------------------------------------
// Input channel: i_sample with i_in_valid; a beat is taken on a rising edge
// with i_in_valid high and o_in_stall low. Output channel: o_position with
// o_out_valid; a beat leaves on a rising edge with o_out_valid high and
// i_out_stall low. One result per sample, in order.
// Configuration: i_cfg_index / i_cfg_data with i_cfg_valid; o_cfg_ready is
// always high. Write only while the pipeline is empty.
// Throughput: one sample per cycle while o_in_stall is low. The pipeline has
// 19 register stages (2 clamp/product stages, 8 divider stages of one
// quotient bit each, 6 expo curve stages, 3 output stages). The divider by
// the calibrated span is what sets the depth.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults. While the receiver stalls, the output register holds
// its beat and empty stages keep filling; o_in_stall rises only once every
// stage holds a beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stick_channel_shaper_unit #(
    parameter int SAMPLE_BITS = stcs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_position,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [stcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    stcs_pkg::t_cfg r_cfg;

    logic                        front_rdy;
    logic                        front_vld;
    logic [stcs_pkg::PROD_W-1:0] front_dvd;
    logic [stcs_pkg::DVS_W-1:0]  front_dvs;
    logic                        front_zero;
    logic                        div_rdy;
    logic                        div_vld;
    logic [7:0]                  div_quot;
    logic                        expo_rdy;
    logic                        expo_vld;
    logic [7:0]                  expo_curve;
    logic [7:0]                  expo_quot;
    logic                        back_rdy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= stcs_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (stcs_pkg::t_cfg_idx'(i_cfg_index))
                stcs_pkg::CFG_LOW_END:       r_cfg.low_end       <= i_cfg_data;
                stcs_pkg::CFG_HIGH_END:      r_cfg.high_end      <= i_cfg_data;
                stcs_pkg::CFG_TRAVEL_RANGE:  r_cfg.travel_range  <= i_cfg_data[6:0];
                stcs_pkg::CFG_TRIM_OFFSET:   r_cfg.trim_offset   <= $signed(i_cfg_data);
                stcs_pkg::CFG_EXPO_PERCENT:  r_cfg.expo_percent  <= i_cfg_data[6:0];
                stcs_pkg::CFG_INVERT_OUTPUT: r_cfg.invert_output <= i_cfg_data[0];
                stcs_pkg::CFG_THROTTLE_MODE: r_cfg.throttle_mode <= i_cfg_data[0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    stcs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_vld     (i_in_valid),
        .i_sample  (i_sample),
        .o_rdy     (front_rdy),
        .i_nxt_rdy (div_rdy),
        .o_vld     (front_vld),
        .o_dvd     (front_dvd),
        .o_dvs     (front_dvs),
        .o_zero    (front_zero)
    );

    stcs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (front_vld),
        .i_dvd     (front_dvd),
        .i_dvs     (front_dvs),
        .i_zero    (front_zero),
        .o_rdy     (div_rdy),
        .i_nxt_rdy (expo_rdy),
        .o_vld     (div_vld),
        .o_quot    (div_quot)
    );

    stcs_expo u_expo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_vld     (div_vld),
        .i_quot    (div_quot),
        .o_rdy     (expo_rdy),
        .i_nxt_rdy (back_rdy),
        .o_vld     (expo_vld),
        .o_curve   (expo_curve),
        .o_quot    (expo_quot)
    );

    stcs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_vld     (expo_vld),
        .i_curve   (expo_curve),
        .i_quot    (expo_quot),
        .o_rdy     (back_rdy),
        .i_nxt_rdy (!i_out_stall),
        .o_vld     (o_out_valid),
        .o_pos     (o_position)
    );

    assign o_in_stall = !front_rdy;

    `STCS_ASSERT(a_stall_only_when_full, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled while output not blocked")
    `STCS_ASSERT(a_position_range, o_out_valid |-> (o_position <= stcs_pkg::POS_MAX), "position beyond 180")
    `STCS_ASSERT_RST(a_reset_empties, !i_rst_n |=> !o_out_valid, "output valid right after reset")

endmodule

FILE: bench/stick_channel_shaper_unit_tb.sv
// ----------------------------------------------------------------------------
// stick_channel_shaper_unit_tb
// Self-checking bench for the stick channel shaper pipeline.
// ----------------------------------------------------------------------------
// Each sample taken by the block is run through a behavioral shaper in the
// bench, and the position it should produce is queued. Every position the
// block hands out is compared in order against that queue. Settings are
// loaded only with the pipeline drained. Coverage comes from a directed
// pass over corner settings, a long output hold-off that backs the pipeline
// up into its input, and random settings with random samples. The sender
// runs in bursts with gaps, and the receiver stalls in shifting patterns.
// ----------------------------------------------------------------------------
module stick_channel_shaper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W    = stcs_pkg::SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [7:0]          position;
    } t_pending;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    logic [SAMPLE_W-1:0]             i_sample    = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [7:0]                      o_position;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [stcs_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [stcs_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    stcs_pkg::t_cfg shaper_cfg = stcs_pkg::CFG_RESET;
    t_pending       expected_positions[$];
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    int             burst_left     = 0;
    bit             hold_req       = 1'b0;

    stick_channel_shaper_unit #(
        .SAMPLE_BITS (SAMPLE_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral shaper
    // ------------------------------------------------------------------------
    // Linear rescale with truncating division; a flat input span gives out_lo.
    function automatic longint linear_map(input longint x, input longint in_lo,
                                          input longint in_hi, input longint out_lo,
                                          input longint out_hi);
        longint span;
        span = in_hi - in_lo;
        if (span == 0)
            return out_lo;
        return (x - in_lo) * (out_hi - out_lo) / span + out_lo;
    endfunction

    function automatic logic [7:0] shape_position(input logic [SAMPLE_W-1:0] raw,
                                                  input stcs_pkg::t_cfg c);
        longint lo, hi, rng, k, v, x, y;
        lo  = c.low_end;
        hi  = c.high_end;
        rng = c.travel_range;
        k   = c.expo_percent;
        v   = raw >> 2;
        // swapped ends fall out of this order of tests
        if (v < lo)
            v = lo;
        else if (v > hi)
            v = hi;
        if (c.throttle_mode) begin
            v = linear_map(v, lo, hi, 0, 2 * rng);
        end else begin
            v = linear_map(v, lo, hi, 0, 255) & 255;
            if (k != 0) begin
                x = v - 127;
                y = (k * x * x * x / 16129 + x * (100 - k)) / 100 + 127;
                v = (y < 0) ? 0 : (y > 255) ? 255 : y;
            end
            v = linear_map(v, 0, 255, 90 - rng, 90 + rng);
        end
        v = v + c.trim_offset;
        if (v < 0)
            v = 0;
        if (v > 180)
            v = 180;
        if (c.invert_output)
            v = 180 - v;
        return v[7:0];
    endfunction

    function automatic stcs_pkg::t_cfg make_cfg(input int lo, input int hi, input int rng,
                                                input int trim, input int expo,
                                                input bit inv, input bit thr);
        stcs_pkg::t_cfg c;
        c.low_end       = lo[7:0];
        c.high_end      = hi[7:0];
        c.travel_range  = rng[6:0];
        c.trim_offset   = trim[7:0];
        c.expo_percent  = expo[6:0];
        c.invert_output = inv;
        c.throttle_mode = thr;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [SAMPLE_W-1:0] s,
                                 input logic [7:0] want, input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] %s: sample %0d expected %0d got %0d",
                     $realtime, what, s, want, got);
    endtask

    // Call at a rising edge; returns at the edge where the beat is taken.
    task automatic offer_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        i_sample   <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_positions.push_back('{sample: s, position: shape_position(s, shaper_cfg)});
    endtask

    // Drop valid and wait for every queued position to come back.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_positions.size() != 0);
    endtask

    // Write all registers; unused upper data bits carry junk.
    task automatic load_settings(input stcs_pkg::t_cfg c);
        stcs_pkg::t_cfg_idx idx;
        logic [7:0] data;
        idx = idx.first();
        repeat (idx.num()) begin
            data = 8'($urandom);
            case (idx)
                stcs_pkg::CFG_LOW_END:       data = c.low_end;
                stcs_pkg::CFG_HIGH_END:      data = c.high_end;
                stcs_pkg::CFG_TRAVEL_RANGE:  data[6:0] = c.travel_range;
                stcs_pkg::CFG_TRIM_OFFSET:   data = c.trim_offset;
                stcs_pkg::CFG_EXPO_PERCENT:  data[6:0] = c.expo_percent;
                stcs_pkg::CFG_INVERT_OUTPUT: data[0] = c.invert_output;
                stcs_pkg::CFG_THROTTLE_MODE: data[0] = c.throttle_mode;
                default:                     data = '0;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            idx = idx.next();
        end
        i_cfg_valid <= 1'b0;
        shaper_cfg = c;
    endtask

    function automatic stcs_pkg::t_cfg random_settings();
        stcs_pkg::t_cfg c;
        int roll;
        c = make_cfg($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 127), $urandom_range(0, 255),
                     $urandom_range(0, 127), $urandom_range(0, 1),
                     $urandom_range(0, 1));
        roll = $urandom_range(0, 9);
        if (roll < 3) begin
            c.low_end  = 8'($urandom_range(0, 60));
            c.high_end = 8'($urandom_range(190, 255));
        end else if (roll == 3) begin
            c.high_end = c.low_end;
        end else if (roll == 4) begin
            c.low_end  = 8'd0;
            c.high_end = 8'd255;
        end
        if ($urandom_range(0, 3) == 0)
            c.expo_percent = 7'd0;
        if ($urandom_range(0, 3) == 0)
            c.travel_range = ($urandom_range(0, 1) == 1) ? 7'd90 : 7'd127;
        case ($urandom_range(0, 5))
            0:       c.trim_offset = 8'sd0;
            1:       c.trim_offset = -8'sd90;
            2:       c.trim_offset = 8'sd90;
            3:       c.trim_offset = ($urandom_range(0, 1) == 1) ? 8'sd127 : -8'sd128;
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int s;
        case ($urandom_range(0, 9))
            0, 1:    s = shaper_cfg.low_end * 4 + $urandom_range(0, 8) - 4;
            2, 3:    s = shaper_cfg.high_end * 4 + $urandom_range(0, 8) - 4;
            4:       s = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
            default: s = $urandom_range(0, SAMPLE_MAX);
        endcase
        if (s < 0)
            s = 0;
        if (s > SAMPLE_MAX)
            s = SAMPLE_MAX;
        return s[SAMPLE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        offer_sample('0);
        offer_sample(SAMPLE_W'(SAMPLE_MAX));
        offer_sample(SAMPLE_W'(10'h155));
        offer_sample(SAMPLE_W'(10'h2AA));
        drain_pipeline();
    endtask

    task automatic test_corner_settings();
        stcs_pkg::t_cfg corners[$];
        corners.push_back(make_cfg(0,   255, 90,  0,    0,   0, 1));
        corners.push_back(make_cfg(0,   255, 90,  -90,  100, 1, 0));
        // flat span, both modes
        corners.push_back(make_cfg(128, 128, 90,  0,    50,  0, 0));
        corners.push_back(make_cfg(0,   0,   60,  10,   0,   0, 1));
        // swapped ends
        corners.push_back(make_cfg(200, 50,  127, 90,   0,   0, 1));
        // curve weight and travel beyond their nominal tops, and zero travel
        corners.push_back(make_cfg(20,  230, 127, -128, 127, 0, 0));
        corners.push_back(make_cfg(0,   255, 0,   127,  30,  1, 0));
        foreach (corners[n]) begin
            load_settings(corners[n]);
            offer_sample('0);
            offer_sample(SAMPLE_W'(514));
            offer_sample(SAMPLE_W'(SAMPLE_MAX));
            drain_pipeline();
        end
    endtask

    // Hold the output long enough that the pipeline fills and stalls its input.
    task automatic test_backpressure();
        load_settings(make_cfg(0, 255, 90, 0, 40, 0, 0));
        hold_req   = 1'b1;
        burst_left = 1000;
        repeat (150) offer_sample(random_sample());
        burst_left = 0;
        drain_pipeline();
    endtask

    task automatic test_random_settings();
        repeat (10) begin
            load_settings(random_settings());
            repeat (85) offer_sample(random_sample());
            drain_pipeline();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checking, receiver stalls, watchdog
    // ------------------------------------------------------------------------
    initial begin : position_check
        t_pending want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_positions.size() == 0) begin
                    note_mismatch("unexpected position", '0, '0, o_position);
                end else begin
                    want = expected_positions.pop_front();
                    if (o_position !== want.position)
                        note_mismatch("position mismatch", want.sample,
                                      want.position, o_position);
                end
            end
        end
    end

    initial begin : out_stall_gen
        int mode;
        int mode_left;
        int n;
        mode_left = 0;
        mode      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            case (mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= (cycle_count % 7 < 3);
            endcase
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("stick_channel_shaper_unit regression: fail");
        $finish;
    end

    initial begin : run_tests
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_corner_settings();
        test_backpressure();
        test_random_settings();
        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_positions.size() == 0) begin
            $display("stick_channel_shaper_unit regression: pass");
        end else begin
            $display("stick_channel_shaper_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/stcs_pkg.sv
hdl/stcs_front.sv
hdl/stcs_div.sv
hdl/stcs_expo.sv
hdl/stcs_back.sv
hdl/stick_channel_shaper_unit.sv
bench/stick_channel_shaper_unit_tb.sv
